@@ sv/wbcm_pkg.sv @@
`timescale 1ns / 1ps

package wbcm_pkg;

   localparam int ADDR_BITS  = 16;
   localparam int COUNT_BITS = 32;

   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   typedef enum logic [1:0] {
      MODE_MARK = 2'd0,
      MODE_LOAD = 2'd1,
      MODE_EXEC = 2'd2,
      MODE_READ = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CSR_REC_EN    = 2'd0,
      CSR_WIN_EN    = 2'd1,
      CSR_WIN_START = 2'd2,
      CSR_WIN_END   = 2'd3
   } csr_type;

   typedef enum logic [1:0] {
      RD_ENTRY    = 2'd0,
      RD_PT_OWNER = 2'd1,
      RD_PF_OWNER = 2'd2
   } rd_sel_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_WRITE,
      ST_X_RD,
      ST_X_ARM,
      ST_PT_RD,
      ST_PT_CHK,
      ST_PT_UPD,
      ST_PF_RD,
      ST_PF_CHK,
      ST_PF_UPD,
      ST_SC_RD,
      ST_SC_UPD,
      ST_CNT_RD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       clr_en;
      logic       accept;
      rd_sel_type rd_sel;
      logic       wr_en;
      logic       arm_en;
      logic       pt_upd;
      logic       pf_upd;
      logic       sc_upd;
      logic       rsp_load;
      logic       rsp_zero;
   } cmd_type;

   typedef struct packed {
      logic     clr_done;
      mode_type mode;
      logic     ok;
      logic     marked;
      logic     pt_nz;
      logic     pf_nz;
      logic     rsp_free;
   } status_type;

   function automatic count_type sat_inc(input count_type v);
      return (v == '1) ? v : v + count_type'(1);
   endfunction

   function automatic logic [31:0] out32(input count_type v);
      logic [63:0] w;
      w = 64'(v);
      return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
   endfunction

endpackage

@@ sv/wbcm_ctrl.sv @@
`timescale 1ns / 1ps

module wbcm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  wbcm_pkg::status_type sts,
   output wbcm_pkg::cmd_type   cmd
);
   import wbcm_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.rd_sel = RD_ENTRY;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (sts.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (sts.mode)
               MODE_MARK, MODE_LOAD: state_in = ST_WRITE;
               MODE_EXEC: state_in = sts.ok ? ST_X_RD : ST_OUT;
               MODE_READ: state_in = ST_CNT_RD;
            endcase
         end
         ST_WRITE: begin
            cmd.wr_en = 1'b1;
            state_in  = ST_OUT;
         end
         ST_X_RD: state_in = ST_X_ARM;
         ST_X_ARM: begin
            if (sts.marked) begin
               cmd.arm_en = 1'b1;
               state_in   = ST_PT_RD;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_PT_RD: state_in = ST_PT_CHK;
         ST_PT_CHK: begin
            cmd.rd_sel = RD_PT_OWNER;
            state_in   = sts.pt_nz ? ST_PT_UPD : ST_PF_RD;
         end
         ST_PT_UPD: begin
            cmd.pt_upd = 1'b1;
            state_in   = ST_PF_RD;
         end
         ST_PF_RD: state_in = ST_PF_CHK;
         ST_PF_CHK: begin
            cmd.rd_sel = RD_PF_OWNER;
            state_in   = sts.pf_nz ? ST_PF_UPD : ST_SC_RD;
         end
         ST_PF_UPD: begin
            cmd.pf_upd = 1'b1;
            state_in   = ST_SC_RD;
         end
         ST_SC_RD: state_in = ST_SC_UPD;
         ST_SC_UPD: begin
            cmd.sc_upd = 1'b1;
            state_in   = ST_CNT_RD;
         end
         ST_CNT_RD: state_in = ST_OUT;
         ST_OUT: begin
            if (sts.rsp_free) begin
               // full counts only for a read or a counted execute
               if ((sts.mode == MODE_READ) || (sts.mode == MODE_EXEC && sts.ok && sts.marked))
               begin
                  cmd.rsp_load = 1'b1;
               end else begin
                  cmd.rsp_zero = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_load || cmd.rsp_zero) |-> sts.rsp_free)
      else $error("transfer loaded while output busy");

   a_arm_marked: assert property (@(posedge clock) disable iff (reset)
      cmd.arm_en |-> (sts.marked && sts.ok && sts.mode == MODE_EXEC))
      else $error("arm without marked statement");

   a_clear_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && !sts.clr_done) |=> state_ff == ST_CLEAR)
      else $error("clearing pass left early");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> state_ff == ST_DISPATCH)
      else $error("accept did not dispatch");

endmodule

@@ sv/wbcm_datapath.sv @@
`timescale 1ns / 1ps

module wbcm_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  wbcm_pkg::cmd_type     cmd,
   output wbcm_pkg::status_type  sts,
   input  logic [1:0]            req_mode,
   input  logic [15:0]           req_entry_address,
   input  logic [15:0]           req_true_target,
   input  logic [15:0]           req_false_target,
   input  logic [31:0]           req_pc_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_counted,
   output logic [31:0]           rsp_statement_count,
   output logic [31:0]           rsp_true_count,
   output logic [31:0]           rsp_false_count,
   input  logic                  csr_write_enable,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_write_data
);
   import wbcm_pkg::*;

   localparam int DEPTH = 1 << ADDR_BITS;

   // config registers
   logic        rec_en_ff, win_en_ff;
   logic [31:0] win_start_ff, win_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_en_ff    <= 1'b1;
         win_en_ff    <= 1'b0;
         win_start_ff <= '0;
         win_end_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_type'(csr_index))
            CSR_REC_EN:    rec_en_ff    <= csr_write_data[0];
            CSR_WIN_EN:    win_en_ff    <= csr_write_data[0];
            CSR_WIN_START: win_start_ff <= csr_write_data;
            CSR_WIN_END:   win_end_ff   <= csr_write_data;
         endcase
      end
   end

   // request capture
   mode_type    mode_ff;
   addr_type    p_ff, tt_ff, ft_ff;
   logic        ok_ff;
   logic [31:0] pc_off;
   logic        ok_in;
   addr_type    p_in;

   always_comb begin
      pc_off = win_en_ff ? (req_pc_value - win_start_ff) : req_pc_value;
      if (mode_type'(req_mode) == MODE_EXEC) begin
         p_in  = pc_off[ADDR_BITS-1:0];
         ok_in = rec_en_ff
            && !(win_en_ff && (req_pc_value < win_start_ff || req_pc_value > win_end_ff))
            && ((pc_off >> ADDR_BITS) == 32'd0);
      end else begin
         p_in  = ADDR_BITS'(req_entry_address);
         ok_in = ((32'(req_entry_address) >> ADDR_BITS) == 32'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff <= mode_type'(req_mode);
         p_ff    <= p_in;
         ok_ff   <= ok_in;
         tt_ff   <= ((32'(req_true_target) >> ADDR_BITS) == 32'd0)
                    ? ADDR_BITS'(req_true_target) : '0;
         ft_ff   <= ((32'(req_false_target) >> ADDR_BITS) == 32'd0)
                    ? ADDR_BITS'(req_false_target) : '0;
      end
   end

   // clearing pass
   addr_type clr_addr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clr_en) begin
         clr_addr_ff <= clr_addr_ff + addr_type'(1);
      end
   end

   // memories
   logic                   mark_mem [DEPTH];
   logic [2*ADDR_BITS-1:0] tgt_mem  [DEPTH];
   addr_type               pt_mem   [DEPTH];
   addr_type               pf_mem   [DEPTH];
   count_type              sc_mem   [DEPTH];
   count_type              tc_mem   [DEPTH];
   count_type              fc_mem   [DEPTH];

   logic                   mark_rd_ff;
   logic [2*ADDR_BITS-1:0] tgt_rd_ff;
   addr_type               pt_rd_ff, pf_rd_ff, owner_ff, rd_addr;
   count_type              sc_rd_ff, tc_rd_ff, fc_rd_ff;
   addr_type               tgt_t, tgt_f;

   assign tgt_t = tgt_rd_ff[2*ADDR_BITS-1:ADDR_BITS];
   assign tgt_f = tgt_rd_ff[ADDR_BITS-1:0];

   always_comb begin
      unique case (cmd.rd_sel)
         RD_PT_OWNER: rd_addr = pt_rd_ff;
         RD_PF_OWNER: rd_addr = pf_rd_ff;
         default:     rd_addr = p_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      mark_rd_ff <= mark_mem[rd_addr];
      tgt_rd_ff  <= tgt_mem[rd_addr];
      pt_rd_ff   <= pt_mem[rd_addr];
      pf_rd_ff   <= pf_mem[rd_addr];
      sc_rd_ff   <= sc_mem[rd_addr];
      tc_rd_ff   <= tc_mem[rd_addr];
      fc_rd_ff   <= fc_mem[rd_addr];
      if (cmd.rd_sel != RD_ENTRY) begin
         owner_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_en) begin
         mark_mem[clr_addr_ff] <= 1'b0;
      end else if (cmd.wr_en && ok_ff && mode_ff == MODE_MARK) begin
         mark_mem[p_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_en) begin
         tgt_mem[clr_addr_ff] <= '0;
      end else if (cmd.wr_en && ok_ff && mode_ff == MODE_LOAD) begin
         tgt_mem[p_ff] <= {tt_ff, ft_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_en) begin
         pt_mem[clr_addr_ff] <= '0;
      end else if (cmd.arm_en && tgt_t != '0 && tgt_f != '0) begin
         pt_mem[tgt_t] <= p_ff;
      end else if (cmd.pt_upd) begin
         pt_mem[p_ff] <= '0;
      end else if (cmd.pf_upd) begin
         pt_mem[tgt_t] <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_en) begin
         pf_mem[clr_addr_ff] <= '0;
      end else if (cmd.arm_en && tgt_t != '0 && tgt_f != '0) begin
         pf_mem[tgt_f] <= p_ff;
      end else if (cmd.pt_upd) begin
         pf_mem[tgt_f] <= '0;
      end else if (cmd.pf_upd) begin
         pf_mem[p_ff] <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_en) begin
         sc_mem[clr_addr_ff] <= '0;
      end else if (cmd.sc_upd) begin
         sc_mem[p_ff] <= sat_inc(sc_rd_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_en) begin
         tc_mem[clr_addr_ff] <= '0;
      end else if (cmd.pt_upd) begin
         tc_mem[owner_ff] <= sat_inc(tc_rd_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_en) begin
         fc_mem[clr_addr_ff] <= '0;
      end else if (cmd.pf_upd) begin
         fc_mem[owner_ff] <= sat_inc(fc_rd_ff);
      end
   end

   // result register
   logic        rsp_valid_ff, rsp_counted_ff;
   logic [31:0] rsp_sc_ff, rsp_tc_ff, rsp_fc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load || cmd.rsp_zero) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_counted_ff <= (mode_ff == MODE_EXEC);
         rsp_sc_ff      <= ok_ff ? out32(sc_rd_ff) : 32'd0;
         rsp_tc_ff      <= ok_ff ? out32(tc_rd_ff) : 32'd0;
         rsp_fc_ff      <= ok_ff ? out32(fc_rd_ff) : 32'd0;
      end else if (cmd.rsp_zero) begin
         rsp_counted_ff <= 1'b0;
         rsp_sc_ff      <= '0;
         rsp_tc_ff      <= '0;
         rsp_fc_ff      <= '0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_counted         = rsp_counted_ff;
   assign rsp_statement_count = rsp_sc_ff;
   assign rsp_true_count      = rsp_tc_ff;
   assign rsp_false_count     = rsp_fc_ff;

   assign sts.clr_done = (clr_addr_ff == '1);
   assign sts.mode     = mode_ff;
   assign sts.ok       = ok_ff;
   assign sts.marked   = mark_rd_ff;
   assign sts.pt_nz    = (pt_rd_ff != '0);
   assign sts.pf_nz    = (pf_rd_ff != '0);
   assign sts.rsp_free = !rsp_valid_ff || !rsp_stall;

endmodule

@@ sv/windowed_branch_coverage_monitor_core.sv @@
// flow: mark and load items pass through dispatch, table write and result load; read items
// through dispatch, count read and result load; execute items through the chain of single-port
// memory reads and writes (arm, true hit, false hit, statement update, count read)
// throughput: one item at a time, next transfer taken once the result is registered
// reset: synchronous; a clearing pass over all 2^ADDR_BITS (65536) entries zeroes every
// table before the first request transfer; config writes are taken meanwhile
`timescale 1ns / 1ps

module windowed_branch_coverage_monitor_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_entry_address,
   input  logic [15:0] req_true_target,
   input  logic [15:0] req_false_target,
   input  logic [31:0] req_pc_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_counted,
   output logic [31:0] rsp_statement_count,
   output logic [31:0] rsp_true_count,
   output logic [31:0] rsp_false_count,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   import wbcm_pkg::*;

   cmd_type    cmd;
   status_type sts;

   wbcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   wbcm_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_mode            (req_mode),
      .req_entry_address   (req_entry_address),
      .req_true_target     (req_true_target),
      .req_false_target    (req_false_target),
      .req_pc_value        (req_pc_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_counted         (rsp_counted),
      .rsp_statement_count (rsp_statement_count),
      .rsp_true_count      (rsp_true_count),
      .rsp_false_count     (rsp_false_count),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

endmodule
